### src/jsu_pkg.sv
// Shared types, character codes and helpers for the JSON string unescaper.
package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_SEEK    = 3'd0,
    PH_STRING  = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_HEX     = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  // Completion status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_UNSUPP = 2'd2
  } status_t;

  // One accepted input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result transaction from the decoder
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    status_t    status;
  } res_t;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // Decode one hex digit: {bad, nibble}; nibble is zero when bad
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b1_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### src/jsu_in_stage.sv
// Input register stage: captures one byte transaction per cycle while it is empty or its held byte moves on.
module jsu_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsu_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              stage_valid,
  output jsu_pkg::in_item_t stage_item
);
  import jsu_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Accept when empty or when the held byte moves on this cycle
  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Load payload on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### src/jsu_decode.sv
// Per-byte string decoder state machine.
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  jsu_pkg::in_item_t item,
  output jsu_pkg::res_t     res
);
  import jsu_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] hex_pos_r, hex_pos_nxt;
  logic [3:0] high_nib_r, high_nib_nxt;
  logic       pnz_r, pnz_nxt;
  logic       hdb_r, hdb_nxt;

  logic [7:0] c;
  logic       last;
  logic [4:0] hex;
  logic       is_ws;

  assign c     = item.data_byte;
  assign last  = item.last_byte;
  assign hex   = hex_decode(c);
  assign is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);

  // State registers, advanced once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEEK;
      hex_pos_r  <= 2'd0;
      high_nib_r <= 4'd0;
      pnz_r      <= 1'b0;
      hdb_r      <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      hex_pos_r  <= hex_pos_nxt;
      high_nib_r <= high_nib_nxt;
      pnz_r      <= pnz_nxt;
      hdb_r      <= hdb_nxt;
    end
  end

  // Next state and result
  always_comb begin
    phase_nxt    = phase_r;
    hex_pos_nxt  = hex_pos_r;
    high_nib_nxt = high_nib_r;
    pnz_nxt      = pnz_r;
    hdb_nxt      = hdb_r;
    res          = '0;
    res.status   = ST_OK;

    case (phase_r)
      PH_STRING: begin
        if (c == CH_QUOTE) begin
          res.valid  = 1'b1;
          res.done_res = 1'b1;
          res.status = ST_OK;
          phase_nxt  = PH_SEEK;
        end else if (last) begin
          res.valid  = 1'b1;
          res.done_res = 1'b1;
          res.status = ST_SYNTAX;
          phase_nxt  = PH_SEEK;
        end else if (c == CH_BSLASH) begin
          phase_nxt = PH_ESCAPE;
        end else begin
          res.valid      = 1'b1;
          res.out_byte   = c;
          res.byte_valid = 1'b1;
        end
      end

      PH_ESCAPE: begin
        if (last) begin
          res.valid    = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_SYNTAX;
          phase_nxt    = PH_SEEK;
        end else begin
          phase_nxt      = PH_STRING;
          res.valid      = 1'b1;
          res.byte_valid = 1'b1;
          case (c)
            CH_QUOTE:  res.out_byte = CH_QUOTE;
            CH_BSLASH: res.out_byte = CH_BSLASH;
            CH_SLASH:  res.out_byte = CH_SLASH;
            CH_LOW_B:  res.out_byte = CH_BS;
            CH_LOW_F:  res.out_byte = CH_FF;
            CH_LOW_N:  res.out_byte = CH_LF;
            CH_LOW_R:  res.out_byte = CH_CR;
            CH_LOW_T:  res.out_byte = CH_TAB;
            CH_LOW_U: begin
              res.valid      = 1'b0;
              res.byte_valid = 1'b0;
              phase_nxt      = PH_HEX;
              hex_pos_nxt    = 2'd0;
              high_nib_nxt   = 4'd0;
              pnz_nxt        = 1'b0;
              hdb_nxt        = 1'b0;
            end
            default: begin
              // Unknown escape letter
              res.byte_valid = 1'b0;
              res.done_res   = 1'b1;
              res.status     = ST_SYNTAX;
              phase_nxt      = PH_DISCARD;
            end
          endcase
        end
      end

      PH_HEX: begin
        if (last) begin
          res.valid    = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_SYNTAX;
          phase_nxt    = PH_SEEK;
        end else if (!hex_pos_r[1]) begin
          // Prefix digits must both be '0'
          if (c != CH_ZERO) begin
            pnz_nxt = 1'b1;
          end
          hex_pos_nxt = hex_pos_r + 2'd1;
        end else if (!hex_pos_r[0]) begin
          hdb_nxt      = hex[4];
          high_nib_nxt = hex[3:0];
          hex_pos_nxt  = 2'd3;
        end else begin
          hex_pos_nxt = 2'd0;
          res.valid   = 1'b1;
          if (pnz_r) begin
            res.done_res = 1'b1;
            res.status   = ST_UNSUPP;
            phase_nxt    = PH_DISCARD;
          end else if (hdb_r || hex[4]) begin
            res.done_res = 1'b1;
            res.status   = ST_SYNTAX;
            phase_nxt    = PH_DISCARD;
          end else begin
            res.out_byte   = {high_nib_r, hex[3:0]};
            res.byte_valid = 1'b1;
            phase_nxt      = PH_STRING;
          end
        end
      end

      PH_DISCARD: begin
        // Drop input through the last byte
        if (last) begin
          phase_nxt = PH_SEEK;
        end
      end

      default: begin
        phase_nxt = PH_SEEK;
        if (is_ws) begin
          if (last) begin
            res.valid    = 1'b1;
            res.done_res = 1'b1;
            res.status   = ST_SYNTAX;
          end
        end else if (c == CH_QUOTE) begin
          if (last) begin
            res.valid    = 1'b1;
            res.done_res = 1'b1;
            res.status   = ST_SYNTAX;
          end else begin
            phase_nxt = PH_STRING;
          end
        end else begin
          res.valid    = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_SYNTAX;
          phase_nxt    = last ? PH_SEEK : PH_DISCARD;
        end
      end
    endcase
  end

  // An error on a non-final byte must enter discard
  a_err_discard: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.valid && res.done_res && (res.status != ST_OK) && !last
    |=> phase_r == PH_DISCARD)
    else $error("error without discard");

  // A final byte always returns the decoder to seeking
  a_last_seek: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && last |=> phase_r == PH_SEEK)
    else $error("last byte did not return to seek");

  // A decoded byte never carries a done mark or status
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res.byte_valid |-> res.valid && !res.done_res && (res.status == ST_OK))
    else $error("byte result with done or status");

  // Leaving the hex phase resets the digit position
  a_hex_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (phase_r == PH_HEX) && !last && (hex_pos_r == 2'd3)
    |=> hex_pos_r == 2'd0)
    else $error("hex position not cleared");

endmodule

### src/json_string_unescaper_unit.sv
// Top level of the JSON string unescaper: input stage, decoder, result register.
//
//  Channel | Ports                                              | Direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_ready, in_data_byte, in_last_byte     | input
//  out     | out_valid, out_ready, out_byte, out_byte_valid,    | output
//          | out_done_res, out_status                           |
//
// One byte per clock sustained while out_ready is held high; a byte's result passes
// through the input register, then the result register, before it is presented.
// Bytes that produce no result (whitespace, opening quote, escape prefix,
// hex digits before the last, discarded input) leave the result register alone.
// Reset (synchronous, rst_n low) empties both registers and returns to seeking.
// A stalled result holds the decoder; the input register still takes one byte.
module json_string_unescaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic [1:0] out_status
);
  import jsu_pkg::*;

  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     advance;
  logic     step_en;
  res_t     res;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_byte_valid_r;
  logic       out_done_res_r;
  status_t    out_status_r;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // Move the held byte on whenever the result register can take a result
  assign advance = !out_valid_r || out_ready;
  assign step_en = stage_valid && advance;

  jsu_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (stage_item),
    .res     (res)
  );

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step_en && res.valid) begin
      out_byte_r       <= res.out_byte;
      out_byte_valid_r <= res.byte_valid;
      out_done_res_r   <= res.done_res;
      out_status_r     <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_byte_valid_r;
  assign out_done_res   = out_done_res_r;
  assign out_status     = out_status_r;

  // A pending result is a byte or a done mark, never both or neither
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_byte_valid_r ^ out_done_res_r))
    else $error("result is neither byte nor done");

  // The decoder never advances while a result is stalled
  a_no_step_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !step_en)
    else $error("decoder stepped into a full result register");

endmodule
